// ----- sv/rsc_pkg.sv -----
// Package for the RPN stack calculator: field widths, opcode and status codes,
// and the request and response types between the sequencer and the serial ALU.
// It depends on nothing else.
package rsc_pkg;

  localparam int DataW   = 32;
  localparam int OpcodeW = 3;
  localparam int StatusW = 2;
  localparam int CountW  = 5;

  // Opcodes of an input beat; codes above divide do nothing.
  localparam logic [OpcodeW-1:0] OP_PUSH = 3'd0;
  localparam logic [OpcodeW-1:0] OP_ADD  = 3'd1;
  localparam logic [OpcodeW-1:0] OP_SUB  = 3'd2;
  localparam logic [OpcodeW-1:0] OP_MUL  = 3'd3;
  localparam logic [OpcodeW-1:0] OP_DIV  = 3'd4;

  // Saturation limits of a signed Q16.16 value.
  localparam logic [DataW-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] Q_MIN = 32'h8000_0000;

  typedef enum logic [StatusW-1:0] {
    ST_OK   = 2'd0,
    ST_FEW  = 2'd1,
    ST_DIV0 = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_t;

  typedef struct packed {
    logic             start;
    alu_op_t          op;
    logic [DataW-1:0] b;
    logic [DataW-1:0] t;
  } alu_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] result;
  } alu_rsp_t;

endpackage

// ----- sv/rsc_ifs.sv -----
// Valid/ready channel interfaces of the RPN stack calculator: the command
// channel and the response channel. They depend on rsc_pkg for widths.
interface rsc_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [rsc_pkg::OpcodeW-1:0]         opcode;
  logic signed [rsc_pkg::DataW-1:0]    push_value;

  modport source (output valid, output opcode, output push_value, input ready);
  modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface rsc_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [rsc_pkg::DataW-1:0]    top_value;
  logic [rsc_pkg::StatusW-1:0]         status;
  logic [rsc_pkg::CountW-1:0]          stack_count;

  modport source (output valid, output top_value, output status, output stack_count,
                  input ready);
  modport sink   (input valid, input top_value, input status, input stack_count,
                  output ready);
endinterface

// ----- sv/rpn_stack_calculator_core.sv -----
// RPN stack calculator: a push, underflow, full stack, unknown opcode or divide by
// zero is answered by the sequencer alone; add, subtract, multiply and divide run
// on the one-bit-per-cycle ALU. One command is in flight at a time; the next is
// taken once the previous response sits in the output register. Reset empties the
// stack; stack memory contents are not cleared.
// Depends on rsc_pkg, rsc_ifs and rsc_alu.
module rpn_stack_calculator_core #(
  parameter int STACK_DEPTH = 16
) (
  input logic      clk,
  input logic      rst,
  rsc_cmd_if.sink   cmd,
  rsc_rsp_if.source rsp
);

  localparam int CntW  = $clog2(STACK_DEPTH + 1);
  localparam int AddrW = $clog2(STACK_DEPTH);
  localparam logic [CntW-1:0] CntFull  = CntW'(STACK_DEPTH);
  localparam logic [CntW-1:0] CntOne   = CntW'(1);
  localparam logic [CntW-1:0] CntTwo   = CntW'(2);
  localparam logic [CntW-1:0] CntThree = CntW'(3);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_RDB, S_ALU, S_RDT, S_DONE} state_t;

  state_t                       state;
  logic [rsc_pkg::OpcodeW-1:0]  op;
  logic [rsc_pkg::DataW-1:0]    val;
  logic [CntW-1:0]              count;
  logic [rsc_pkg::DataW-1:0]    top;
  rsc_pkg::status_t             status;
  logic                         out_valid;
  logic [rsc_pkg::DataW-1:0]    out_top;
  rsc_pkg::status_t             out_status;
  logic [rsc_pkg::CountW-1:0]   out_count;
  rsc_pkg::alu_req_t            alu_req;
  rsc_pkg::alu_rsp_t            alu_rsp;

  logic [rsc_pkg::DataW-1:0]    mem [STACK_DEPTH];
  logic                         mem_we;
  logic [AddrW-1:0]             mem_waddr;
  logic [rsc_pkg::DataW-1:0]    mem_wdata;
  logic                         mem_re;
  logic [AddrW-1:0]             mem_raddr;
  logic [rsc_pkg::DataW-1:0]    mem_rdata;

  logic [CntW-1:0]              cnt_m2;
  logic [CntW-1:0]              cnt_m3;
  logic                         is_arith;
  logic                         div_zero;
  rsc_pkg::alu_op_t             alu_op;

  rsc_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Decode of the held command.
  always_comb begin
    cnt_m2   = count - CntTwo;
    cnt_m3   = count - CntThree;
    is_arith = (op == rsc_pkg::OP_ADD) || (op == rsc_pkg::OP_SUB) ||
               (op == rsc_pkg::OP_MUL) || (op == rsc_pkg::OP_DIV);
    div_zero = (op == rsc_pkg::OP_DIV) && (top == '0);
    priority case (op)
      rsc_pkg::OP_SUB: alu_op = rsc_pkg::ALU_SUB;
      rsc_pkg::OP_MUL: alu_op = rsc_pkg::ALU_MUL;
      rsc_pkg::OP_DIV: alu_op = rsc_pkg::ALU_DIV;
      default:         alu_op = rsc_pkg::ALU_ADD;
    endcase
  end

  // Stack memory port control: the top entry lives in a register, so at most
  // one entry below it is read per step.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count[AddrW-1:0];
    mem_wdata = val;
    mem_re    = 1'b0;
    mem_raddr = cnt_m2[AddrW-1:0];
    unique case (state)
      S_EXEC: begin
        if ((op == rsc_pkg::OP_PUSH) && (count != CntFull)) begin
          mem_we = 1'b1;
        end
        if (is_arith && (count >= CntTwo)) begin
          mem_re = 1'b1;
        end
      end
      S_RDB: begin
        if (div_zero && (count >= CntThree)) begin
          mem_re    = 1'b1;
          mem_raddr = cnt_m3[AddrW-1:0];
        end
      end
      S_ALU: begin
        if (alu_rsp.done) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_m2[AddrW-1:0];
          mem_wdata = alu_rsp.result;
        end
      end
      S_IDLE, S_RDT, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Stack memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  // Command sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      top           <= '0;
      out_valid     <= 1'b0;
      alu_req.start <= 1'b0;
    end else begin
      alu_req.start <= (state == S_RDB) && !div_zero;
      // A response beat leaves the register unless a new one replaces it.
      if (out_valid && rsp.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            op    <= cmd.opcode;
            val   <= cmd.push_value;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (op == rsc_pkg::OP_PUSH) begin
            state <= S_DONE;
            if (count == CntFull) begin
              status <= rsc_pkg::ST_FULL;
            end else begin
              status <= rsc_pkg::ST_OK;
              count  <= count + CntOne;
              top    <= val;
            end
          end else if (is_arith) begin
            if (count < CntTwo) begin
              status <= rsc_pkg::ST_FEW;
              state  <= S_DONE;
            end else begin
              status <= rsc_pkg::ST_OK;
              state  <= S_RDB;
            end
          end else begin
            status <= rsc_pkg::ST_OK;
            state  <= S_DONE;
          end
        end
        S_RDB: begin
          if (div_zero) begin
            // Both operands go, nothing is pushed; the new top is read back.
            status <= rsc_pkg::ST_DIV0;
            count  <= cnt_m2;
            if (count >= CntThree) begin
              state <= S_RDT;
            end else begin
              top   <= '0;
              state <= S_DONE;
            end
          end else begin
            alu_req.op    <= alu_op;
            alu_req.b     <= mem_rdata;
            alu_req.t     <= top;
            state         <= S_ALU;
          end
        end
        S_ALU: begin
          if (alu_rsp.done) begin
            count <= count - CntOne;
            top   <= alu_rsp.result;
            state <= S_DONE;
          end
        end
        S_RDT: begin
          top   <= mem_rdata;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_top    <= top;
            out_status <= status;
            out_count  <= rsc_pkg::CountW'(count);
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign cmd.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.top_value   = out_top;
  assign rsp.status      = out_status;
  assign rsp.stack_count = out_count;

endmodule

// ----- sv/rsc_alu.sv -----
// Serial arithmetic unit of the RPN stack calculator: bit-serial add and
// subtract, shift-add multiply and restoring divide, all saturating to Q16.16.
// It depends on rsc_pkg for the request and response types.
module rsc_alu (
  input  logic              clk,
  input  logic              rst,
  input  rsc_pkg::alu_req_t req,
  output rsc_pkg::alu_rsp_t rsp
);

  localparam int CntW = 6;
  localparam int DqW  = 48;
  localparam logic [CntW-1:0] LastAdd = 6'd32;
  localparam logic [CntW-1:0] LastMul = 6'd31;
  localparam logic [CntW-1:0] LastDiv = 6'd47;

  typedef enum logic [1:0] {A_IDLE, A_RUN, A_FIX} astate_t;

  astate_t          state;
  rsc_pkg::alu_op_t op;
  logic [CntW-1:0]  cnt;
  logic [31:0]      x;
  logic [31:0]      y;
  logic [32:0]      acc;
  logic [DqW-1:0]   dq;
  logic             carry;
  logic             neg;
  logic             done;
  logic [31:0]      result;

  logic [31:0]      abs_b;
  logic [31:0]      abs_t;
  logic             add_tb;
  logic             add_s;
  logic             add_c;
  logic             mul_sub;
  logic [32:0]      mul_bx;
  logic [32:0]      mul_add;
  logic [32:0]      mul_sum;
  logic [33:0]      div_diff;
  logic             div_ge;
  logic [31:0]      div_rem;
  logic             last;
  logic             div_big;
  logic [31:0]      sat;

  // Operand magnitudes for the divider.
  always_comb begin
    abs_b = req.b[31] ? (~req.b + 32'd1) : req.b;
    abs_t = req.t[31] ? (~req.t + 32'd1) : req.t;
  end

  // One step of each serial datapath.
  always_comb begin
    add_tb   = y[0] ^ (op == rsc_pkg::ALU_SUB);
    add_s    = x[0] ^ add_tb ^ carry;
    add_c    = (x[0] & add_tb) | (x[0] & carry) | (add_tb & carry);

    // The sign bit of a two's complement multiplier has negative weight.
    mul_sub  = (cnt == LastMul);
    mul_bx   = {x[31], x};
    mul_add  = y[0] ? (mul_sub ? ~mul_bx : mul_bx) : 33'd0;
    mul_sum  = {acc[31], acc[31:0]} + mul_add + {32'd0, y[0] & mul_sub};

    div_diff = {1'b0, acc[31:0], dq[DqW-1]} - {2'b00, y};
    div_ge   = !div_diff[33];
    div_rem  = div_ge ? div_diff[31:0] : {acc[30:0], dq[DqW-1]};

    unique case (op)
      rsc_pkg::ALU_ADD, rsc_pkg::ALU_SUB: last = (cnt == LastAdd);
      rsc_pkg::ALU_MUL:                   last = (cnt == LastMul);
      rsc_pkg::ALU_DIV:                   last = (cnt == LastDiv);
    endcase
  end

  // Saturation of the finished value.
  always_comb begin
    div_big = |dq[DqW-1:32];
    unique case (op)
      rsc_pkg::ALU_ADD, rsc_pkg::ALU_SUB: begin
        if (acc[32] != acc[31]) begin
          sat = acc[32] ? rsc_pkg::Q_MIN : rsc_pkg::Q_MAX;
        end else begin
          sat = acc[31:0];
        end
      end
      rsc_pkg::ALU_MUL: begin
        // The product is {acc[31:0], y}; the result keeps bits 47 to 16.
        if ((&acc[31:15]) || !(|acc[31:15])) begin
          sat = {acc[15:0], y[31:16]};
        end else begin
          sat = acc[31] ? rsc_pkg::Q_MIN : rsc_pkg::Q_MAX;
        end
      end
      rsc_pkg::ALU_DIV: begin
        if (neg) begin
          if (div_big || (dq[31] && (|dq[30:0]))) begin
            sat = rsc_pkg::Q_MIN;
          end else begin
            sat = ~dq[31:0] + 32'd1;
          end
        end else begin
          if (div_big || dq[31]) begin
            sat = rsc_pkg::Q_MAX;
          end else begin
            sat = dq[31:0];
          end
        end
      end
    endcase
  end

  // Sequencer of the serial datapaths.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      op    <= rsc_pkg::ALU_ADD;
      done  <= 1'b0;
    end else begin
      done <= (state == A_FIX);
      unique case (state)
        A_IDLE: begin
          if (req.start) begin
            op    <= req.op;
            cnt   <= '0;
            carry <= (req.op == rsc_pkg::ALU_SUB);
            neg   <= req.b[31] ^ req.t[31];
            acc   <= '0;
            x     <= req.b;
            dq    <= {abs_b, 16'd0};
            y     <= (req.op == rsc_pkg::ALU_DIV) ? abs_t : req.t;
            state <= A_RUN;
          end
        end
        A_RUN: begin
          unique case (op)
            rsc_pkg::ALU_ADD, rsc_pkg::ALU_SUB: begin
              x     <= {x[31], x[31:1]};
              y     <= {y[31], y[31:1]};
              acc   <= {add_s, acc[32:1]};
              carry <= add_c;
            end
            rsc_pkg::ALU_MUL: begin
              acc <= {1'b0, mul_sum[32:1]};
              y   <= {mul_sum[0], y[31:1]};
            end
            rsc_pkg::ALU_DIV: begin
              acc <= {1'b0, div_rem};
              dq  <= {dq[DqW-2:0], div_ge};
            end
          endcase
          cnt <= cnt + 6'd1;
          if (last) begin
            state <= A_FIX;
          end
        end
        A_FIX: begin
          result <= sat;
          state  <= A_IDLE;
        end
        default: state <= A_IDLE;
      endcase
    end
  end

  assign rsp.done   = done;
  assign rsp.result = result;

endmodule

// ----- tb/rpn_step_checker.sv -----
// Checker for the RPN stack calculator: it watches the command and response
// channels, keeps its own copy of the operand stack and compares every response
// beat with the predicted one. It depends on rsc_pkg and rsc_ifs.
module rpn_step_checker #(
  parameter int Depth = 16
) (
  input  logic clk,
  input  logic rst,
  rsc_cmd_if   cmd,
  rsc_rsp_if   rsp,
  output int   mismatches,
  output int   outstanding
);
  import rsc_pkg::*;

  typedef struct packed {
    logic [DataW-1:0]  top;
    status_t           status;
    logic [CountW-1:0] count;
  } step_outcome_t;

  localparam longint QHi = longint'($signed(Q_MAX));
  localparam longint QLo = longint'($signed(Q_MIN));

  // Predicted operand stack and the outcomes still owed by the block.
  logic [DataW-1:0] stack_mem [Depth];
  int unsigned      held;
  step_outcome_t    owed_outcomes [$];

  // Saturate a wide intermediate to the signed Q16.16 range.
  function automatic logic [DataW-1:0] clamp_q(input longint v);
    if (v > QHi) begin
      v = QHi;
    end else if (v < QLo) begin
      v = QLo;
    end
    return v[DataW-1:0];
  endfunction

  // Apply one command to the predicted stack and return what the block should report.
  function automatic step_outcome_t evaluate_item(input logic [OpcodeW-1:0] opcode,
                                                  input logic [DataW-1:0]   value);
    step_outcome_t res;
    longint        b;
    longint        t;
    longint        r;
    logic          keep;
    res.status = ST_OK;
    r          = 0;
    keep       = 1'b1;
    if (opcode == OP_PUSH) begin
      if (held >= Depth) begin
        res.status = ST_FULL;
      end else begin
        stack_mem[held] = value;
        held++;
      end
    end else if (opcode <= OP_DIV) begin
      if (held < 2) begin
        res.status = ST_FEW;
      end else begin
        t    = longint'($signed(stack_mem[held-1]));
        b    = longint'($signed(stack_mem[held-2]));
        held = held - 2;
        case (opcode)
          OP_ADD: r = b + t;
          OP_SUB: r = b - t;
          // The arithmetic shift rounds the product toward minus infinity.
          OP_MUL: r = (b * t) >>> 16;
          default: begin
            if (t == 0) begin
              res.status = ST_DIV0;
              keep       = 1'b0;
            end else begin
              r = (b * 65536) / t;
            end
          end
        endcase
        if (keep) begin
          stack_mem[held] = clamp_q(r);
          held++;
        end
      end
    end
    res.top   = (held > 0) ? stack_mem[held-1] : '0;
    res.count = CountW'(held);
    return res;
  endfunction

  // Predict on each command beat and compare on each response beat.
  always @(posedge clk) begin
    step_outcome_t want;
    if (rst) begin
      held        = 0;
      mismatches  = 0;
      owed_outcomes.delete();
    end else begin
      if (cmd.valid && cmd.ready) begin
        owed_outcomes.push_back(evaluate_item(cmd.opcode, cmd.push_value));
      end
      if (rsp.valid && rsp.ready) begin
        if (owed_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: response beat with nothing owed: top %h status %0d count %0d",
                     $time, rsp.top_value, rsp.status, rsp.stack_count);
          end
        end else begin
          want = owed_outcomes.pop_front();
          if (rsp.top_value !== want.top || rsp.status !== want.status ||
              rsp.stack_count !== want.count) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: step mismatch: top %h/%h status %0d/%0d count %0d/%0d (exp/got)",
                       $time, want.top, rsp.top_value, want.status, rsp.status,
                       want.count, rsp.stack_count);
            end
          end
        end
      end
    end
    outstanding = owed_outcomes.size();
  end

endmodule

// ----- tb/rpn_stack_calculator_core_tb.sv -----
// Top of the RPN stack calculator testbench: clock, reset, command stimulus and
// response back-pressure, with the verdict taken from rpn_step_checker.
// It depends on rsc_pkg, rsc_ifs, the calculator core and the checker.
module rpn_stack_calculator_core_tb;
  import rsc_pkg::*;

  localparam int Depth      = 16;
  localparam int ItemTarget = 1500;

  logic clk;
  logic rst;
  int   mismatches;
  int   outstanding;
  int   beats_sent    = 0;
  int   burst_left    = 0;
  bit   hold_off_req  = 1'b0;
  bit   hold_off_done = 1'b0;

  rsc_cmd_if cmd_ch ();
  rsc_rsp_if rsp_ch ();

  rpn_stack_calculator_core #(
    .STACK_DEPTH(Depth)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch)
  );

  rpn_step_checker #(
    .Depth(Depth)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_ch),
    .rsp        (rsp_ch),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard limit on the run, far beyond the slowest correct one.
  initial begin
    #4000000;
    $display("rpn_stack_calculator_core test failed");
    $finish;
  end

  // Operand values weighted toward the interesting corners of Q16.16.
  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return Q_MAX;
      2:       return Q_MIN;
      3:       return DataW'(($urandom_range(0, 40) - 20) * 65536);
      4:       return DataW'(int'($urandom_range(0, 524288)) - 262144);
      5:       return $urandom_range(0, 1) ? DataW'(1) : '1;
      default: return DataW'($urandom);
    endcase
  endfunction

  function automatic logic [OpcodeW-1:0] pick_operator();
    return OpcodeW'($urandom_range(OP_ADD, OP_DIV));
  endfunction

  // Offer one command beat, opening a random gap whenever a burst runs out.
  task automatic issue(input logic [OpcodeW-1:0] opcode, input logic [DataW-1:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        cmd_ch.valid      = 1'b0;
        cmd_ch.opcode     = OpcodeW'($urandom);
        cmd_ch.push_value = $urandom;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    @(negedge clk);
    cmd_ch.valid      = 1'b1;
    cmd_ch.opcode     = opcode;
    cmd_ch.push_value = value;
    do @(posedge clk); while (!cmd_ch.ready);
    beats_sent++;
  endtask

  // Response back-pressure: random stall patterns, plus one long hold-off on request.
  initial begin : receiver
    int mode;
    int mode_left;
    rsp_ch.ready = 1'b0;
    mode         = 0;
    mode_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        rsp_ch.ready  = 1'b0;
        repeat (300) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(1, 40);
      end
      mode_left--;
      case (mode)
        0:       rsp_ch.ready = 1'b1;
        1:       rsp_ch.ready = ($urandom_range(0, 9) < 7);
        default: rsp_ch.ready = ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  // Command stimulus: directed corners first, then random postfix sequences.
  initial begin : sender
    int  kind;
    int  k;
    bit  paused;
    paused            = 1'b0;
    rst               = 1'b1;
    cmd_ch.valid      = 1'b0;
    cmd_ch.opcode     = OP_PUSH;
    cmd_ch.push_value = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Every operator on an empty stack underflows.
    issue(OP_ADD, '0);
    issue(OP_SUB, '0);
    issue(OP_MUL, '0);
    issue(OP_DIV, '0);
    // One entry is still too few operands.
    issue(OP_PUSH, Q_MAX);
    issue(OP_ADD, '0);
    // Unknown opcodes leave the stack alone.
    for (int c = OP_DIV + 1; c < 2 ** OpcodeW; c++) begin
      issue(OpcodeW'(c), DataW'($urandom));
    end
    // Addition and subtraction saturating at the top of the range.
    issue(OP_PUSH, DataW'(1));
    issue(OP_ADD, '0);
    issue(OP_PUSH, Q_MIN);
    issue(OP_SUB, '0);
    // A tiny negative product rounds toward minus infinity.
    issue(OP_PUSH, 32'hFFFF_8000);
    issue(OP_PUSH, DataW'(1));
    issue(OP_MUL, '0);
    // Divide by zero consumes both operands.
    issue(OP_PUSH, '0);
    issue(OP_DIV, '0);
    // Quotient overflow saturates negative.
    issue(OP_PUSH, '1);
    issue(OP_DIV, '0);
    // Product overflow saturates negative.
    issue(OP_PUSH, Q_MAX);
    issue(OP_MUL, '0);

    while (beats_sent < ItemTarget) begin
      if (!hold_off_req && beats_sent >= 500) begin
        hold_off_req = 1'b1;
      end
      // Let the block drain completely once, with no command on offer.
      if (!paused && beats_sent >= 1000) begin
        paused = 1'b1;
        @(negedge clk);
        cmd_ch.valid = 1'b0;
        wait (outstanding == 0);
      end
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3: begin
          k = $urandom_range(2, 5);
          repeat (k) issue(OP_PUSH, pick_value());
          repeat (k - 1) issue(pick_operator(), pick_value());
        end
        4, 5: begin
          repeat ($urandom_range(1, 3)) issue(OP_PUSH, pick_value());
          repeat ($urandom_range(1, 3)) issue(pick_operator(), pick_value());
        end
        6: begin
          repeat ($urandom_range(14, 20)) issue(OP_PUSH, pick_value());
        end
        7: begin
          repeat ($urandom_range(4, 18)) issue(pick_operator(), pick_value());
        end
        default: begin
          repeat ($urandom_range(4, 12)) issue(OpcodeW'($urandom), pick_value());
        end
      endcase
    end

    @(negedge clk);
    cmd_ch.valid = 1'b0;
    wait (outstanding == 0);
    repeat (64) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("rpn_stack_calculator_core test passed");
    end else begin
      $display("rpn_stack_calculator_core test failed");
    end
    $finish;
  end

endmodule
